/* rtl/core/bcdc_pkg.sv */
// Package for the button click / double-click detector.
// Holds the event codes, register indexes, reset values, queue depth and the queued event type.
// No dependencies.
package bcdc_pkg;

	// Default width of the elapsed-tick counter.
	localparam int TIMER_WIDTH_DEF = 16;

	// Configuration register reset values.
	localparam logic [15:0] DEBOUNCE_TICKS_RST = 16'd20;
	localparam logic [15:0] WINDOW_TICKS_RST   = 16'd500;

	// Register indexes (selected by the word address).
	localparam logic REG_DEBOUNCE = 1'b0;
	localparam logic REG_WINDOW   = 1'b1;

	// Event codes.
	localparam logic [1:0] EV_PRESS_DOWN   = 2'd0;
	localparam logic [1:0] EV_CLICK        = 2'd1;
	localparam logic [1:0] EV_DOUBLE_CLICK = 2'd2;
	localparam logic [1:0] EV_RELEASE      = 2'd3;

	// Depth of the event queue in front of the output port.
	localparam int EVQ_DEPTH = 4;
	localparam int EVQ_PTR_W = $clog2(EVQ_DEPTH);
	localparam int EVQ_CNT_W = $clog2(EVQ_DEPTH + 1);

	typedef struct packed {
		logic [1:0] code;
		logic       last;
	} bcdc_event_t;

endpackage

/* rtl/core/button_click_double_click_detector.sv */
// Button click / double-click detector, top level.
// Depends on bcdc_pkg for event codes, reset values and the event type.
//
// Usage: every request on the s_ channel is one timer tick; s_tdata[0] is the
// sampled button level (1 pressed). The block turns the level stream into
// events on the m_ channel: press-down once a press has held for the debounce
// time, release on every confirmed release, double-click after the release
// that ends a second press, and click when the double-click window expires or
// when a second press bounces away. A tick causes zero, one or two events;
// m_tlast marks the final event of a tick.
// Throughput: one tick per cycle while s_tready is high. The tick is
// evaluated by the phase machine in the cycle it is accepted, and its events
// are written into a four-entry event queue whose head drives m_. The output
// drains one event per cycle while m_tready is high; s_tready stays high
// while the queue has room for two events, which is always the case while
// the receiver keeps up. When the receiver stalls, the queue fills and
// s_tready drops until it drains again. Reset clears the phase machine, the
// counter, the queue and loads the register defaults (20 and 500 ticks). The
// APB port is always ready; registers sit at byte addresses 0 and 4.
module button_click_double_click_detector
	import bcdc_pkg::*;
#(
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Tick input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] button_down, [7:1] zero
	// Event output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [1:0] event_code, [7:2] zero
	output logic        m_tlast,   // last_event
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Phase machine codes.
	localparam logic [1:0] PH_IDLE     = 2'd0;
	localparam logic [1:0] PH_DEBOUNCE = 2'd1;
	localparam logic [1:0] PH_PRESSED  = 2'd2;
	localparam logic [1:0] PH_WAIT     = 2'd3;

	// The compare runs at the wider of the counter and the 16-bit thresholds,
	// so a threshold above the saturated counter value never fires.
	localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
	localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

	// Configuration registers.
	logic [15:0] debounce_ticks_q;
	logic [15:0] window_ticks_q;

	// Phase machine state.
	logic [1:0]             phase_q;
	logic [TIMER_WIDTH-1:0] elapsed_q;
	logic                   pending_q;

	// Event queue.
	bcdc_event_t              evq_q [EVQ_DEPTH];
	logic [EVQ_PTR_W-1:0]     wr_ptr_q;
	logic [EVQ_PTR_W-1:0]     rd_ptr_q;
	logic [EVQ_CNT_W-1:0]     count_q;

	// Next-state and event logic.
	logic                   accept;
	logic                   pop;
	logic                   down;
	logic [TIMER_WIDTH-1:0] elapsed_inc;
	logic                   debounce_hit;
	logic                   window_hit;
	logic [1:0]             phase_d;
	logic [TIMER_WIDTH-1:0] elapsed_d;
	logic                   pending_d;
	logic [1:0]             push_n;
	bcdc_event_t            ev0;
	bcdc_event_t            ev1;
	logic                   cfg_write;

	assign accept = s_tvalid && s_tready;
	assign pop    = m_tvalid && m_tready;
	assign down   = s_tdata[0];

	// Saturating increment, applied before the compare in the timed phases.
	assign elapsed_inc  = (elapsed_q == TIMER_MAX) ? elapsed_q : elapsed_q + 1'b1;
	assign debounce_hit = CMP_W'(elapsed_inc) >= CMP_W'(debounce_ticks_q);
	assign window_hit   = CMP_W'(elapsed_inc) >= CMP_W'(window_ticks_q);

	always_comb begin
		phase_d   = phase_q;
		elapsed_d = elapsed_q;
		pending_d = pending_q;
		push_n    = 2'd0;
		ev0.code  = EV_PRESS_DOWN;
		ev0.last  = 1'b1;
		ev1.code  = EV_DOUBLE_CLICK;
		ev1.last  = 1'b1;
		unique case (phase_q)
			PH_IDLE: begin
				if (down) begin
					phase_d   = PH_DEBOUNCE;
					elapsed_d = '0;
					pending_d = 1'b0;
				end
			end
			PH_DEBOUNCE: begin
				elapsed_d = elapsed_inc;
				// A released level wins over the debounce compare.
				if (!down) begin
					if (pending_q) begin
						pending_d = 1'b0;
						ev0.code  = EV_CLICK;
						push_n    = 2'd1;
					end
					phase_d = PH_IDLE;
				end else if (debounce_hit) begin
					phase_d  = PH_PRESSED;
					ev0.code = EV_PRESS_DOWN;
					push_n   = 2'd1;
				end
			end
			PH_PRESSED: begin
				if (!down) begin
					ev0.code = EV_RELEASE;
					if (pending_q) begin
						pending_d = 1'b0;
						ev0.last  = 1'b0;
						push_n    = 2'd2;
						phase_d   = PH_IDLE;
					end else begin
						push_n    = 2'd1;
						phase_d   = PH_WAIT;
						elapsed_d = '0;
					end
				end
			end
			PH_WAIT: begin
				elapsed_d = elapsed_inc;
				if (down) begin
					phase_d   = PH_DEBOUNCE;
					elapsed_d = '0;
					pending_d = 1'b1;
				end else if (window_hit) begin
					phase_d  = PH_IDLE;
					ev0.code = EV_CLICK;
					push_n   = 2'd1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			elapsed_q <= '0;
			pending_q <= 1'b0;
		end else if (accept) begin
			phase_q   <= phase_d;
			elapsed_q <= elapsed_d;
			pending_q <= pending_d;
		end
	end

	// Event queue: up to two writes per tick, one read per cycle while m_tready is high.
	always_ff @(posedge clk) begin
		if (accept && (push_n != 2'd0)) begin
			evq_q[wr_ptr_q] <= ev0;
		end
		if (accept && (push_n == 2'd2)) begin
			evq_q[wr_ptr_q + 1'b1] <= ev1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + EVQ_PTR_W'(push_n);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (accept ? EVQ_CNT_W'(push_n) : '0)
				- EVQ_CNT_W'(pop);
		end
	end

	// Room for the two events a tick can cause.
	assign s_tready = count_q <= EVQ_CNT_W'(EVQ_DEPTH - 2);
	assign m_tvalid = count_q != '0;
	assign m_tdata  = {6'd0, evq_q[rd_ptr_q].code};
	assign m_tlast  = evq_q[rd_ptr_q].last;

	// Configuration port. Address bit 2 selects the register.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q <= DEBOUNCE_TICKS_RST;
			window_ticks_q   <= WINDOW_TICKS_RST;
		end else if (cfg_write) begin
			unique case (paddr[2])
				REG_DEBOUNCE: debounce_ticks_q <= pwdata[15:0];
				REG_WINDOW:   window_ticks_q   <= pwdata[15:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_DEBOUNCE: prdata = {16'd0, debounce_ticks_q};
			REG_WINDOW:   prdata = {16'd0, window_ticks_q};
		endcase
	end

	// The queue never holds more events than it has entries.
	a_evq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= EVQ_CNT_W'(EVQ_DEPTH))
		else $error("event queue overflow");

	// A second press is only tracked while debouncing or pressed.
	a_pending_phase: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q |-> (phase_q == PH_DEBOUNCE || phase_q == PH_PRESSED))
		else $error("second press pending outside debounce or pressed phase");

	// Two events only come from a release that ends a second press.
	a_double_src: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && push_n == 2'd2) |-> (phase_q == PH_PRESSED && pending_q && !down))
		else $error("two events from an unexpected phase");

	// After a tick with two events, at least two events are queued.
	a_double_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && push_n == 2'd2) |=> (count_q >= EVQ_CNT_W'(2)))
		else $error("double event not queued");

endmodule

/* sim/tb_button_click_double_click_detector.sv */
// Testbench for the button click / double-click detector.
// Depends on bcdc_pkg and button_click_double_click_detector from the RTL tree.
// Ticks stream in on s_, events are predicted per tick and checked in order on m_.
module tb_button_click_double_click_detector
	import bcdc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// Phases of the button machine, as tracked by the predictor.
	typedef enum logic [1:0] {
		ST_IDLE     = 2'd0,
		ST_DEBOUNCE = 2'd1,
		ST_PRESSED  = 2'd2,
		ST_WAIT     = 2'd3
	} btn_state_t;

	localparam int MAX_SHOWN = 10;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [0] button_down, [7:1] zero
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;   // [1:0] event_code, [7:2] zero
	logic        m_tlast;   // last_event
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Predictor state: a private copy of the registers and the button machine.
	logic [15:0]                debounce_cfg = DEBOUNCE_TICKS_RST;
	logic [15:0]                window_cfg   = WINDOW_TICKS_RST;
	btn_state_t                 btn_state    = ST_IDLE;
	logic [TIMER_WIDTH_DEF-1:0] elapsed      = '0;
	logic                       second_press = 1'b0;

	// Events predicted but not yet seen on the output, oldest first.
	bcdc_event_t events_due[$];

	int mismatches     = 0;
	int ticks_sent     = 0;
	int source_gap_pct = 10;
	int sink_stall_pct = 10;

	button_click_double_click_detector uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #6 clk = ~clk;

	// The receiver stalls at random; a zero stall rate keeps it always ready.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Advance the predicted button machine by one tick and queue the events
	// that the tick causes. The counter saturates instead of wrapping, and in
	// debouncing a released level wins over the debounce compare.
	task automatic advance_button_fsm(input logic down);
		bcdc_event_t evs [2];
		int          n;
		n = 0;
		case (btn_state)
			ST_IDLE: begin
				if (down) begin
					btn_state    = ST_DEBOUNCE;
					elapsed      = '0;
					second_press = 1'b0;
				end
			end
			ST_DEBOUNCE: begin
				if (elapsed != '1)
					elapsed++;
				if (!down) begin
					// A second press that bounces away still counts as a click.
					if (second_press) begin
						second_press = 1'b0;
						evs[n] = '{code: EV_CLICK, last: 1'b0};
						n++;
					end
					btn_state = ST_IDLE;
				end else if (elapsed >= debounce_cfg) begin
					btn_state = ST_PRESSED;
					evs[n] = '{code: EV_PRESS_DOWN, last: 1'b0};
					n++;
				end
			end
			ST_PRESSED: begin
				if (!down) begin
					evs[n] = '{code: EV_RELEASE, last: 1'b0};
					n++;
					if (second_press) begin
						// Release of a confirmed second press: double-click.
						second_press = 1'b0;
						evs[n] = '{code: EV_DOUBLE_CLICK, last: 1'b0};
						n++;
						btn_state = ST_IDLE;
					end else begin
						btn_state = ST_WAIT;
						elapsed   = '0;
					end
				end
			end
			default: begin
				if (elapsed != '1)
					elapsed++;
				if (down) begin
					btn_state    = ST_DEBOUNCE;
					elapsed      = '0;
					second_press = 1'b1;
				end else if (elapsed >= window_cfg) begin
					// No second press inside the window: a single click.
					btn_state = ST_IDLE;
					evs[n] = '{code: EV_CLICK, last: 1'b0};
					n++;
				end
			end
		endcase
		if (n > 0)
			evs[n - 1].last = 1'b1;
		for (int i = 0; i < n; i++)
			events_due.push_back(evs[i]);
	endtask

	// Send one tick request. An optional gap with s_tvalid low comes first;
	// otherwise s_tvalid stays high straight from the previous request.
	task automatic send_tick(input logic down);
		if ($urandom_range(99) < source_gap_pct) begin
			s_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < 50);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'b0, down};
		do
			@(posedge clk);
		while (!s_tready);
		advance_button_fsm(down);
		ticks_sent++;
	endtask

	task automatic send_levels(input logic down, input int count);
		repeat (count)
			send_tick(down);
	endtask

	// Stop sending, wait for every predicted event, then give the block a few
	// more cycles so that any stray event would still show up.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (events_due.size() != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle held until pready. The upper
	// half of pwdata carries random bits that the block must ignore.
	task automatic write_reg(input logic idx, input logic [15:0] value);
		logic [15:0] junk;
		junk = 16'($urandom());
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {junk, value};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_DEBOUNCE: debounce_cfg = value;
			REG_WINDOW:   window_cfg   = value;
		endcase
	endtask

	task automatic set_timing(input logic [15:0] debounce, input logic [15:0] window);
		write_reg(REG_DEBOUNCE, debounce);
		write_reg(REG_WINDOW, window);
	endtask

	// Random tick count near a threshold: from 1 up to three past it, just at it,
	// just past it, or well past it, so that every compare is hit from both sides.
	function automatic int near_threshold(input logic [15:0] thr);
		case ($urandom_range(3))
			0:       return int'($urandom_range(int'(thr) + 3, 1));
			1:       return int'(thr) + 1;
			2:       return int'(thr) + 2;
			default: return int'(thr) + int'($urandom_range(6, 3));
		endcase
	endfunction

	// Reset values: 20 ticks of debounce and a 500-tick window, exercised by a
	// double click made of two long presses.
	task automatic test_reset_defaults();
		send_levels(1'b1, 21);
		send_levels(1'b0, 4);
		send_levels(1'b1, 21);
		send_tick(1'b0);
		settle();
	endtask

	// A first press that bounces away, then a plain click that times out.
	task automatic test_single_click();
		set_timing(16'd1, 16'd0);
		send_tick(1'b1);
		send_tick(1'b0);
		send_levels(1'b1, 2);
		send_levels(1'b0, 2);
		settle();
	endtask

	// Second press inside the window, held and released: release then double-click.
	task automatic test_double_click();
		set_timing(16'd0, 16'd2);
		send_levels(1'b1, 2);
		send_tick(1'b0);
		send_levels(1'b1, 2);
		send_tick(1'b0);
		settle();
	endtask

	// Second press that bounces away during debouncing reports a click.
	task automatic test_second_press_bounce();
		send_levels(1'b1, 2);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		settle();
	endtask

	// Largest register values: a press that cannot reach the debounce time,
	// and a double click inside the widest window.
	task automatic test_register_extremes();
		set_timing(16'hFFFF, 16'd0);
		send_levels(1'b1, 3);
		send_tick(1'b0);
		settle();
		set_timing(16'd0, 16'hFFFF);
		send_levels(1'b1, 2);
		send_levels(1'b0, 3);
		send_levels(1'b1, 2);
		send_tick(1'b0);
		settle();
	endtask

	// Mostly well-formed press/release sequences whose lengths straddle the
	// thresholds, with about one in ten bursts of random levels as noise.
	task automatic test_random_sessions(input logic [15:0] debounce,
			input logic [15:0] window, input int count);
		int stop_at;
		set_timing(debounce, window);
		stop_at = ticks_sent + count;
		while (ticks_sent < stop_at) begin
			if ($urandom_range(9) == 0) begin
				repeat ($urandom_range(4, 1))
					send_tick(1'($urandom_range(1)));
			end else begin
				send_levels(1'b1, near_threshold(debounce_cfg));
				send_levels(1'b0, near_threshold(window_cfg));
			end
		end
		settle();
	endtask

	// Output checker: each accepted event is compared with the oldest prediction.
	always @(posedge clk) begin
		bcdc_event_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (events_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("%0t: unexpected event code %0d last %0b",
						$realtime, m_tdata[1:0], m_tlast);
			end else begin
				want = events_due.pop_front();
				if (m_tdata[1:0] !== want.code || m_tlast !== want.last) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display({"%0t: event mismatch: expected code %0d last %0b,",
							" got code %0d last %0b"},
							$realtime, want.code, want.last, m_tdata[1:0], m_tlast);
				end
			end
		end
	end

	// Main sequence: reset once, directed checks, then random sessions.
	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		repeat (2)
			@(posedge clk);

		test_reset_defaults();
		test_single_click();
		test_double_click();
		test_second_press_bounce();
		test_register_extremes();

		test_random_sessions(16'd0, 16'd0, 140);
		test_random_sessions(16'd1, 16'd1, 140);
		test_random_sessions(16'($urandom_range(6)), 16'($urandom_range(10)), 140);
		// A long stretch with neither side idling.
		source_gap_pct = 0;
		sink_stall_pct = 0;
		test_random_sessions(16'($urandom_range(6)), 16'($urandom_range(10)), 140);
		source_gap_pct = 10;
		sink_stall_pct = 10;
		test_random_sessions(16'($urandom_range(6)), 16'($urandom_range(10)), 140);

		if (mismatches == 0 && events_due.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/bcdc_pkg.sv
rtl/core/button_click_double_click_detector.sv
sim/tb_button_click_double_click_detector.sv
